// File: rtl/mf3_pkg.sv
// Package for the 3x3 median filter: shared types, constants and
// compare helpers. No dependencies.

package mf3_pkg;

   // Pixel and port geometry
   localparam int PIX_W      = 8;
   localparam int POS_W      = 11;
   localparam int CFG_W      = 12;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Defaults for the top-level size parameters
   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   // Frame size after reset
   localparam int SIZE_RESET = 512;
   localparam int SIZE_MIN   = 3;

   // Result bundle queue depth (power of two)
   localparam int QUEUE_DEPTH = 8;

   // Number of neighbourhoods per word and window geometry
   localparam int NUM_VARIANTS = 4;
   localparam int WIN_SIDE     = 3;
   localparam int WIN_CELLS    = 9;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef logic [PIX_W-1:0] pix_type;

   // Per-word control flags traveling down the pipeline
   typedef struct packed {
      logic valid;
      logic row_first;
      logic col_first;
      logic row_last;
      logic col_last;
      logic emit;
   } item_flags_type;

   // Last index of a clamped frame dimension
   function automatic int size_last(input int v, input int hi);
      int s;
      s = v;
      if (s < SIZE_MIN) s = SIZE_MIN;
      if (s > hi) s = hi;
      return s - 1;
   endfunction

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

// File: rtl/mf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.

module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mf3_line_window.sv
// Line stores and 3x3 window: read-modify-write of the two line stores
// (one RAM, upper and lower side by side) and the window shift.
// Depends on mf3_pkg and mf3_ram.

module mf3_line_window #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT,
   parameter int COL_W     = $clog2(MAX_WIDTH),
   parameter int ROW_W     = $clog2(mf3_pkg::MAX_HEIGHT_DEFAULT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mf3_pkg::item_flags_type       in_flags,
   input  mf3_pkg::pix_type              in_pixel,
   input  logic [COL_W-1:0]              in_col,
   input  logic [ROW_W-1:0]              in_row,
   output mf3_pkg::pix_type [8:0]        window,
   output mf3_pkg::item_flags_type       win_flags,
   output logic [COL_W-1:0]              win_col,
   output logic [ROW_W-1:0]              win_row
);

   localparam int LINE_W = 2 * mf3_pkg::PIX_W;

   // Word waiting for its line-store read
   mf3_pkg::item_flags_type s1_flags_ff;
   mf3_pkg::pix_type        s1_pixel_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [ROW_W-1:0]        s1_row_ff;

   // Word whose window is now current
   mf3_pkg::item_flags_type s2_flags_ff, s2_flags_in;
   logic [COL_W-1:0]        s2_col_ff;
   logic [ROW_W-1:0]        s2_row_ff;

   mf3_pkg::pix_type [8:0]  window_ff, window_in;

   logic [LINE_W-1:0]       line_rd;
   mf3_pkg::pix_type        top, mid;

   mf3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_flags_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_pixel_ff}),
      .rd_en   (in_flags.valid),
      .rd_addr (in_col),
      .rd_data (line_rd)
   );

   // On the first row both stores take the new pixel
   always_comb begin
      if (s1_flags_ff.row_first) begin
         top = s1_pixel_ff;
         mid = s1_pixel_ff;
      end else begin
         top = line_rd[LINE_W-1:mf3_pkg::PIX_W];
         mid = line_rd[mf3_pkg::PIX_W-1:0];
      end
   end

   // Window shift; column zero fills all three columns
   always_comb begin
      window_in = window_ff;
      if (s1_flags_ff.valid) begin
         if (s1_flags_ff.col_first) begin
            for (int j = 0; j < mf3_pkg::WIN_SIDE; j++) begin
               window_in[j]     = top;
               window_in[3 + j] = mid;
               window_in[6 + j] = s1_pixel_ff;
            end
         end else begin
            for (int i = 0; i < mf3_pkg::WIN_SIDE; i++) begin
               window_in[i * 3 + 0] = window_ff[i * 3 + 1];
               window_in[i * 3 + 1] = window_ff[i * 3 + 2];
            end
            window_in[2] = top;
            window_in[5] = mid;
            window_in[8] = s1_pixel_ff;
         end
      end
   end

   assign s2_flags_in = s1_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_flags_ff <= '0;
         s2_flags_ff <= '0;
         window_ff   <= '0;
      end else begin
         s1_flags_ff <= in_flags;
         s2_flags_ff <= s2_flags_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= in_pixel;
      s1_col_ff   <= in_col;
      s1_row_ff   <= in_row;
      s2_col_ff   <= s1_col_ff;
      s2_row_ff   <= s1_row_ff;
   end

   assign window    = window_ff;
   assign win_flags = s2_flags_ff;
   assign win_col   = s2_col_ff;
   assign win_row   = s2_row_ff;

endmodule

// File: rtl/mf3_median9.sv
// Three-stage median of nine: sort rows, then max of mins, median of
// medians and min of maxes, then a final median of three. Depends on mf3_pkg.

module mf3_median9 (
   input  logic                   clock,
   input  mf3_pkg::pix_type [8:0] cells,
   output mf3_pkg::pix_type       median
);

   mf3_pkg::pix_type lo_ff [3], md_ff [3], hi_ff [3];
   mf3_pkg::pix_type lo_in [3], md_in [3], hi_in [3];
   mf3_pkg::pix_type mn_ff, mm_ff, mx_ff;
   mf3_pkg::pix_type mn_in, mm_in, mx_in;
   mf3_pkg::pix_type med_ff, med_in;

   // Stage A: sort each row
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = mf3_pkg::min3(cells[i * 3], cells[i * 3 + 1], cells[i * 3 + 2]);
         md_in[i] = mf3_pkg::med3(cells[i * 3], cells[i * 3 + 1], cells[i * 3 + 2]);
         hi_in[i] = mf3_pkg::max3(cells[i * 3], cells[i * 3 + 1], cells[i * 3 + 2]);
      end
   end

   // Stage B: combine the sorted rows
   always_comb begin
      mn_in = mf3_pkg::max3(lo_ff[0], lo_ff[1], lo_ff[2]);
      mm_in = mf3_pkg::med3(md_ff[0], md_ff[1], md_ff[2]);
      mx_in = mf3_pkg::min3(hi_ff[0], hi_ff[1], hi_ff[2]);
   end

   // Stage C: final pick
   assign med_in = mf3_pkg::med3(mn_ff, mm_ff, mx_ff);

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      md_ff  <= md_in;
      hi_ff  <= hi_in;
      mn_ff  <= mn_in;
      mm_ff  <= mm_in;
      mx_ff  <= mx_in;
      med_ff <= med_in;
   end

   assign median = med_ff;

endmodule

// File: rtl/mf3_median_bank.sv
// Four medians per word: the plain neighbourhood and the mirrored ones
// for the bottom row and right column, with the flags delayed to match.
// Depends on mf3_pkg and mf3_median9.

module mf3_median_bank #(
   parameter int COL_W = $clog2(mf3_pkg::MAX_WIDTH_DEFAULT),
   parameter int ROW_W = $clog2(mf3_pkg::MAX_HEIGHT_DEFAULT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mf3_pkg::pix_type [8:0]        window,
   input  mf3_pkg::item_flags_type       win_flags,
   input  logic [COL_W-1:0]              win_col,
   input  logic [ROW_W-1:0]              win_row,
   output mf3_pkg::pix_type [3:0]        medians,
   output mf3_pkg::item_flags_type       med_flags,
   output logic [COL_W-1:0]              med_col,
   output logic [ROW_W-1:0]              med_row
);

   localparam int DEPTH = 3;

   mf3_pkg::pix_type [8:0]  sel [mf3_pkg::NUM_VARIANTS];

   mf3_pkg::item_flags_type flags_ff [DEPTH];
   logic [COL_W-1:0]        col_ff   [DEPTH];
   logic [ROW_W-1:0]        row_ff   [DEPTH];

   // Variant bit 0 picks rows {mid, new, new}, bit 1 picks columns {1, 2, 2}
   for (genvar v = 0; v < mf3_pkg::NUM_VARIANTS; v++) begin : g_var
      for (genvar i = 0; i < mf3_pkg::WIN_SIDE; i++) begin : g_row
         for (genvar j = 0; j < mf3_pkg::WIN_SIDE; j++) begin : g_col
            localparam int RI = ((v % 2) == 1) ? ((i == 0) ? 1 : 2) : i;
            localparam int CJ = ((v / 2) == 1) ? ((j == 0) ? 1 : 2) : j;
            assign sel[v][i * 3 + j] = window[RI * 3 + CJ];
         end
      end
      mf3_median9 u_med (
         .clock  (clock),
         .cells  (sel[v]),
         .median (medians[v])
      );
   end

   // Flag delay line matching the median pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            flags_ff[k] <= '0;
         end
      end else begin
         flags_ff[0] <= win_flags;
         for (int k = 1; k < DEPTH; k++) begin
            flags_ff[k] <= flags_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff[0] <= win_col;
      row_ff[0] <= win_row;
      for (int k = 1; k < DEPTH; k++) begin
         col_ff[k] <= col_ff[k - 1];
         row_ff[k] <= row_ff[k - 1];
      end
   end

   assign med_flags = flags_ff[DEPTH - 1];
   assign med_col   = col_ff[DEPTH - 1];
   assign med_row   = row_ff[DEPTH - 1];

endmodule

// File: rtl/mf3_outq.sv
// Result queue: holds one bundle of up to four medians per word and
// hands them out one result word at a time. Depends on mf3_pkg.

module mf3_outq #(
   parameter int COL_W = $clog2(mf3_pkg::MAX_WIDTH_DEFAULT),
   parameter int ROW_W = $clog2(mf3_pkg::MAX_HEIGHT_DEFAULT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mf3_pkg::pix_type [3:0]          medians,
   input  mf3_pkg::item_flags_type         med_flags,
   input  logic [COL_W-1:0]                med_col,
   input  logic [ROW_W-1:0]                med_row,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mf3_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int QD    = mf3_pkg::QUEUE_DEPTH;
   localparam int QA    = $clog2(QD);
   localparam int CNT_W = $clog2(QD + 1);
   localparam int PW    = mf3_pkg::POS_W;
   localparam int PAD_W = mf3_pkg::RSP_DATA_W - mf3_pkg::PIX_W - 2 * PW;

   mf3_pkg::pix_type [3:0] med_mem_ff  [QD];
   logic [3:0]             mask_mem_ff [QD];
   logic [COL_W-1:0]       col_mem_ff  [QD];
   logic [ROW_W-1:0]       row_mem_ff  [QD];

   logic [QA-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       sent_ff, sent_in;

   logic             push;
   logic [3:0]       push_mask;
   logic [3:0]       pend, cur, rest;
   logic [1:0]       kind;
   logic             nonempty, handshake;
   logic [ROW_W-1:0] row_v;
   logic [COL_W-1:0] col_v;
   logic [ROW_W+PW-1:0] row_ext;
   logic [COL_W+PW-1:0] col_ext;

   // Results a word causes: plain, bottom row, right column, corner
   assign push = med_flags.valid;
   always_comb begin
      if (med_flags.emit) begin
         push_mask = {med_flags.row_last & med_flags.col_last, med_flags.col_last,
                      med_flags.row_last, 1'b1};
      end else begin
         push_mask = 4'b0000;
      end
   end

   // Head bundle: next pending result, lowest first
   assign nonempty  = (cnt_ff != '0);
   assign pend      = mask_mem_ff[rp_ff] & ~sent_ff;
   assign cur       = pend & (~pend + 4'd1);
   assign rest      = pend & ~cur;
   assign kind      = {cur[3] | cur[2], cur[3] | cur[1]};
   assign rsp_tvalid = nonempty && (pend != 4'b0000);
   assign handshake = rsp_tvalid && rsp_tready;
   assign pop       = nonempty && ((pend == 4'b0000) || (handshake && (rest == 4'b0000)));

   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = 4'b0000;
      end else if (handshake) begin
         sent_in = sent_ff | cur;
      end
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         sent_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
         sent_ff <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         med_mem_ff[wp_ff]  <= medians;
         mask_mem_ff[wp_ff] <= push_mask;
         col_mem_ff[wp_ff]  <= med_col;
         row_mem_ff[wp_ff]  <= med_row;
      end
   end

   // Position of the result: the plain one trails by a row and a column
   assign row_v   = kind[0] ? row_mem_ff[rp_ff] : row_mem_ff[rp_ff] - 1'b1;
   assign col_v   = kind[1] ? col_mem_ff[rp_ff] : col_mem_ff[rp_ff] - 1'b1;
   assign row_ext = {{PW{1'b0}}, row_v};
   assign col_ext = {{PW{1'b0}}, col_v};

   assign rsp_tdata = {{PAD_W{1'b0}}, col_ext[PW-1:0], row_ext[PW-1:0],
                       med_mem_ff[rp_ff][kind]};
   assign rsp_tuser = (kind == 2'b11);
   assign rsp_tlast = (rest == 4'b0000);

endmodule

// File: rtl/median_filter_3x3_top.sv
// A word passes the line-store read, the window, three median stages and the
// queue. Throughput: one pixel per clock until the 8-word credit is used up;
// a pixel off row and column zero on the last row or column gives two or four
// result words, one per clock while rsp_tready is high. Reset clears the
// counters, the window and the queue and sets both sizes to 512; the
// line-store RAM keeps its contents and needs no clearing pass.
//
// Top level of the 3x3 median filter: config registers, raster counters and
// input credit. Depends on mf3_pkg, mf3_line_window, mf3_median_bank, mf3_outq.

module median_filter_3x3_top #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [7:0] pixel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mf3_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: [7:0] median, [18:8] out_row, [29:19] out_col, [31:30] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mf3_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: [0] frame_done
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [mf3_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [mf3_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int OCC_W = $clog2(mf3_pkg::QUEUE_DEPTH + 1);

   logic [COL_W-1:0] wlast_ff, wlast_in;
   logic [ROW_W-1:0] hlast_ff, hlast_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic accept, cfg_hit, pop;

   mf3_pkg::item_flags_type in_flags, win_flags, med_flags;
   mf3_pkg::pix_type [8:0]  window;
   mf3_pkg::pix_type [3:0]  medians;
   logic [COL_W-1:0]        win_col, med_col;
   logic [ROW_W-1:0]        win_row, med_row;

   assign req_tready = (occ_ff < OCC_W'(mf3_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign cfg_hit    = csr_we && ((csr_addr == mf3_pkg::REG_FRAME_WIDTH) ||
                                  (csr_addr == mf3_pkg::REG_FRAME_HEIGHT));

   // Size registers hold the last column and row index after clamping
   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_we) begin
         case (csr_addr)
            mf3_pkg::REG_FRAME_WIDTH:
               wlast_in = COL_W'(mf3_pkg::size_last(int'(csr_wdata), MAX_WIDTH));
            mf3_pkg::REG_FRAME_HEIGHT:
               hlast_in = ROW_W'(mf3_pkg::size_last(int'(csr_wdata), MAX_HEIGHT));
            default: ;
         endcase
      end
   end

   // Raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Words accepted and not yet retired from the queue
   always_comb begin
      case ({accept, pop})
         2'b10:   occ_in = occ_ff + 1'b1;
         2'b01:   occ_in = occ_ff - 1'b1;
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= COL_W'(mf3_pkg::size_last(mf3_pkg::SIZE_RESET, MAX_WIDTH));
         hlast_ff <= ROW_W'(mf3_pkg::size_last(mf3_pkg::SIZE_RESET, MAX_HEIGHT));
         col_ff   <= '0;
         row_ff   <= '0;
         occ_ff   <= '0;
      end else begin
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         occ_ff   <= occ_in;
      end
   end

   // Flags of the word being accepted
   always_comb begin
      in_flags.valid     = accept;
      in_flags.row_first = (row_ff == '0);
      in_flags.col_first = (col_ff == '0);
      in_flags.row_last  = (row_ff == hlast_ff);
      in_flags.col_last  = (col_ff == wlast_ff);
      in_flags.emit      = (row_ff != '0) && (col_ff != '0);
   end

   mf3_line_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W),
      .ROW_W     (ROW_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_flags  (in_flags),
      .in_pixel  (req_tdata[mf3_pkg::PIX_W-1:0]),
      .in_col    (col_ff),
      .in_row    (row_ff),
      .window    (window),
      .win_flags (win_flags),
      .win_col   (win_col),
      .win_row   (win_row)
   );

   mf3_median_bank #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .window    (window),
      .win_flags (win_flags),
      .win_col   (win_col),
      .win_row   (win_row),
      .medians   (medians),
      .med_flags (med_flags),
      .med_col   (med_col),
      .med_row   (med_row)
   );

   mf3_outq #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .medians    (medians),
      .med_flags  (med_flags),
      .med_col    (med_col),
      .med_row    (med_row),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/mf3_checker.sv
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_top.

module mf3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mf3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // The frame's final word is also the last word of its pixel
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_done without last");

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Reset frees all input credit
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (.*);
